// ===== hdl/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared constants, codes and controller/datapath bundles of the rANS encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

    // Field widths of the input and result beats
    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int FREQ_W = 13;
    localparam int CUM_W  = 12;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // Coder geometry
    localparam int SCALE_BITS       = 12;
    localparam int LOWER_BOUND_BITS = 23;
    localparam int ALPHABET_SIZE    = 256;
    localparam int STATE_W          = 32;
    localparam int STATE_BYTES      = STATE_W / BYTE_W;

    // Renormalize while state >= freq << RENORM_SHIFT; the quotient then fits RENORM_SHIFT bits
    localparam int RENORM_SHIFT = LOWER_BOUND_BITS - SCALE_BITS + BYTE_W;
    localparam int QUOT_W       = RENORM_SHIFT;
    localparam int DIV_W        = FREQ_W + RENORM_SHIFT - 1;
    localparam int CMP_W        = (STATE_W > FREQ_W + RENORM_SHIFT) ?
                                  STATE_W : FREQ_W + RENORM_SHIFT;
    localparam int TBL_IDX_W    = $clog2(ALPHABET_SIZE);
    localparam int CNT_W        = $clog2(QUOT_W + 1);

    localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LOWER_BOUND_BITS;
    localparam logic [SYM_W:0]     SYM_LIMIT   = (SYM_W + 1)'(ALPHABET_SIZE);
    localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(QUOT_W - 1);
    localparam logic [CNT_W-1:0]   FLUSH_LAST  = CNT_W'(STATE_BYTES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_RENORM = 2'd0,
        KIND_FINAL  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [CUM_W-1:0]  cum;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic  tbl_wr;
        logic  tbl_rd;
        logic  emit;
        t_kind emit_kind;
        logic  emit_last;
        logic  shift_state;
        logic  div_init;
        logic  div_step;
        logic  state_update;
        logic  state_reset;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic freq_zero;
        logic need_renorm;
        logic renorm_last;
    } t_dp_status;

endpackage

// ===== hdl/rbe_in_if.sv =====
// ----------------------------------------------------------------------------
// rbe_in_if
// Input channel: op, symbol and table fields with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbe_in_if;
    import rbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum_start;

    modport source (output valid, output op, output symbol, output freq,
                    output cum_start, input ready);
    modport sink   (input valid, input op, input symbol, input freq,
                    input cum_start, output ready);
endinterface

// ===== hdl/rbe_out_if.sv =====
// ----------------------------------------------------------------------------
// rbe_out_if
// Result channel: emitted byte, kind and last flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbe_out_if;
    import rbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              last;

    modport source (output valid, output out_byte, output kind, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last,
                    output ready);
endinterface

// ===== hdl/rans_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// rans_byte_encoder
// Byte-wise rANS encoder, 32-bit state, 12-bit probability scale.
//
// Feed symbols in reverse order. A load beat writes the frequency and
// cumulative start of one symbol into a 256-entry table (no result).
// An encode beat reads the table as it is accepted; then it emits one
// renormalization byte at a time while the result slot is free (zero to two,
// low byte first, the last one marked), runs the radix-2 restoring divider
// that forms state / freq and state mod freq, and writes the new state.
// A symbol with zero or never-loaded frequency yields a single error beat
// (byte zero, last set) and leaves the state as is. A flush beat yields the
// four state bytes little-endian, the fourth marked last, then returns the
// state to 2^23. Results sit in an output register, so the next input beat
// is taken while the last result of the previous one still waits. Reset
// clears the table's valid flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rans_byte_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbe_in_if.sink    i_in,
    rbe_out_if.source o_out
);
    import rbe_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // Ready comes from the sequencer; payload goes straight to the datapath
    assign i_in.ready = w_in_ready;

    rbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbe_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

// ===== hdl/rbe_datapath.sv =====
// ----------------------------------------------------------------------------
// rbe_datapath
// Symbol table, coder state, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module rbe_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rbe_in_if.sink              i_in,
    rbe_out_if.source           o_out,
    input  rbe_pkg::t_dp_cmd    i_cmd,
    output rbe_pkg::t_dp_status o_status
);
    import rbe_pkg::*;

    t_entry                   r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_tbl_vld;
    t_entry                   r_rd_entry;
    logic                     r_rd_hit;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [STATE_W-1:0] r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [QUOT_W-1:0]  r_quot;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    t_kind             r_out_kind;
    logic              r_out_last;

    logic [TBL_IDX_W-1:0] w_idx;
    logic                 w_in_range;
    logic [FREQ_W-1:0]    w_freq;
    logic [CMP_W-1:0]     w_xmax;
    logic                 w_ge;

    assign w_idx      = i_in.symbol[TBL_IDX_W-1:0];
    assign w_in_range = {1'b0, i_in.symbol} < SYM_LIMIT;
    assign w_freq     = r_rd_hit ? r_rd_entry.freq : '0;
    assign w_xmax     = CMP_W'(w_freq) << RENORM_SHIFT;
    assign w_ge       = CMP_W'(r_rem) >= CMP_W'(r_div);

    assign o_status.out_free    = !r_out_valid || o_out.ready;
    assign o_status.freq_zero   = (w_freq == '0);
    assign o_status.need_renorm = CMP_W'(r_state) >= w_xmax;
    assign o_status.renorm_last = CMP_W'(r_state >> BYTE_W) < w_xmax;

    // Table: write on load, registered read on encode
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && w_in_range) begin
            r_mem[w_idx] <= '{freq: i_in.freq, cum: i_in.cum_start};
        end
        if (i_cmd.tbl_rd) begin
            r_rd_entry <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_cmd.tbl_wr && w_in_range) begin
                r_tbl_vld[w_idx] <= 1'b1;
            end
            if (i_cmd.tbl_rd) begin
                r_rd_hit <= w_in_range && r_tbl_vld[w_idx];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        priority if (i_cmd.state_reset) begin
            n_state = LOWER_BOUND;
        end else if (i_cmd.state_update) begin
            n_state = (STATE_W'(r_quot) << SCALE_BITS) + r_rem
                      + STATE_W'(r_rd_entry.cum);
        end else if (i_cmd.shift_state) begin
            n_state = r_state >> BYTE_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LOWER_BOUND;
        end else begin
            r_state <= n_state;
        end
    end

    // Restoring divider, one quotient bit a cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= r_state;
            r_div  <= DIV_W'(w_freq) << (RENORM_SHIFT - 1);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= STATE_W'(CMP_W'(r_rem) - CMP_W'(r_div));
            end
            r_div  <= r_div >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= (i_cmd.emit_kind == KIND_ERROR) ? '0 : r_state[BYTE_W-1:0];
            r_out_kind <= i_cmd.emit_kind;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.kind     = r_out_kind;
    assign o_out.last     = r_out_last;

`ifndef SYNTHESIS
    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || o_out.ready))
        else $error("result loaded over a beat not yet taken");

    a_remainder_below_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.state_update |-> (r_rem < STATE_W'(w_freq)))
        else $error("divider remainder not below frequency");

    a_error_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ERROR) |-> (r_out_byte == '0 && r_out_last))
        else $error("error beat with nonzero byte or without last");
`endif

endmodule

// ===== hdl/rbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbe_ctrl
// Sequencer for load, encode (lookup, renormalize, divide, update) and flush.
// ----------------------------------------------------------------------------
module rbe_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [rbe_pkg::OP_W-1:0] i_in_op,
    output logic                    o_in_ready,
    input  rbe_pkg::t_dp_status     i_status,
    output rbe_pkg::t_dp_cmd        o_cmd
);
    import rbe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV,
        ST_UPDATE,
        ST_FLUSH
    } t_state;

    t_state           r_st;
    logic [CNT_W-1:0] r_cnt;

    assign o_in_ready = (r_st == ST_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_kind = KIND_RENORM;
        unique case (r_st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_op)
                        OP_LOAD:   o_cmd.tbl_wr = 1'b1;
                        OP_ENCODE: o_cmd.tbl_rd = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                priority if (i_status.freq_zero) begin
                    o_cmd.emit      = i_status.out_free;
                    o_cmd.emit_kind = KIND_ERROR;
                    o_cmd.emit_last = 1'b1;
                end else if (i_status.need_renorm) begin
                    o_cmd.emit        = i_status.out_free;
                    o_cmd.emit_kind   = KIND_RENORM;
                    o_cmd.emit_last   = i_status.renorm_last;
                    o_cmd.shift_state = i_status.out_free;
                end else begin
                    o_cmd.div_init = 1'b1;
                end
            end
            ST_DIV:    o_cmd.div_step     = 1'b1;
            ST_UPDATE: o_cmd.state_update = 1'b1;
            ST_FLUSH: begin
                o_cmd.emit        = i_status.out_free;
                o_cmd.emit_kind   = KIND_FINAL;
                o_cmd.emit_last   = (r_cnt == FLUSH_LAST);
                o_cmd.shift_state = i_status.out_free;
                o_cmd.state_reset = i_status.out_free && (r_cnt == FLUSH_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        unique case (i_in_op)
                            OP_ENCODE: r_st <= ST_LOOKUP;
                            OP_FLUSH:  r_st <= ST_FLUSH;
                            default:   r_st <= ST_IDLE;
                        endcase
                    end
                end
                ST_LOOKUP: begin
                    priority if (i_status.freq_zero) begin
                        if (i_status.out_free) begin
                            r_st <= ST_IDLE;
                        end
                    end else if (!i_status.need_renorm) begin
                        r_st <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_st <= ST_UPDATE;
                    end
                end
                ST_UPDATE: r_st <= ST_IDLE;
                ST_FLUSH: begin
                    if (i_status.out_free) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == FLUSH_LAST) begin
                            r_st <= ST_IDLE;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_flush_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FLUSH) |-> (r_cnt <= FLUSH_LAST))
        else $error("flush byte count overran the state width");

    a_div_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count overran the quotient width");

    a_div_ends_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV && r_cnt == DIV_LAST) |=> (r_st == ST_UPDATE))
        else $error("divider did not hand over to the state update");
`endif

endmodule

// ===== tb/sv/rans_byte_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// rans_byte_encoder_tb
// Self-checking bench for the byte-wise rANS encoder. A driver pulls input
// beats from a queue: first a directed set of corner cases, then random
// well-formed table/encode/flush sequences mixed with noise. A shadow coder
// predicts every result beat. A monitor compares each result beat, field by
// field, with the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module rans_byte_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbe_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 160;
    localparam int unsigned TAIL_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] freq;
        logic [CUM_W-1:0]  cum;
    } t_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_kind             kind;
        logic              last;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rbe_in_if  in_if ();
    rbe_out_if out_if ();

    rans_byte_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the coder: state register and symbol table
    logic [STATE_W-1:0] coder_x;
    logic [FREQ_W-1:0]  freq_of [ALPHABET_SIZE];
    logic [CUM_W-1:0]   cum_of  [ALPHABET_SIZE];

    t_beat   send_beats[$];     // input beats still to be driven
    t_result expected_bytes[$]; // predicted result beats, oldest first

    t_beat       cur_beat;
    t_result     want;
    int unsigned send_gap;
    int unsigned stall_left;
    bit          calm_in;
    bit          calm_out;
    int unsigned mismatches;
    int unsigned cycle_cnt;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Most gaps are zero or short; a few are long. A calm side never idles.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Append one predicted result beat at the tail of the expect queue
    task automatic add_expected(input t_result r);
        expected_bytes.insert(expected_bytes.size(), r);
    endtask

    // Advance the shadow coder by one accepted beat and queue its results.
    task automatic advance_coder(input t_beat b);
        logic [63:0] x;
        logic [63:0] f;
        logic [63:0] c;
        logic [63:0] limit;
        int unsigned n;
        n = 0;
        case (b.op)
            OP_LOAD: begin
                freq_of[b.symbol] = b.freq;
                cum_of[b.symbol]  = b.cum;
            end
            OP_ENCODE: begin
                f = 64'(freq_of[b.symbol]);
                c = 64'(cum_of[b.symbol]);
                if (f == 0) begin
                    // Unused symbol: one error beat, state held
                    add_expected(t_result'{'0, KIND_ERROR, 1'b1});
                end else begin
                    limit = f << RENORM_SHIFT;
                    x     = 64'(coder_x);
                    // Shift out low bytes while the state is too large;
                    // mark the one after which the loop stops
                    while (x >= limit && n < STATE_BYTES) begin
                        add_expected(t_result'{x[7:0], KIND_RENORM,
                            !((x >> 8) >= limit && n + 1 < STATE_BYTES)});
                        x = x >> 8;
                        n++;
                    end
                    x       = ((x / f) << SCALE_BITS) + (x % f) + c;
                    coder_x = x[STATE_W-1:0];
                end
            end
            OP_FLUSH: begin
                for (int k = 0; k < STATE_BYTES; k++)
                    add_expected(t_result'{coder_x[8*k +: 8], KIND_FINAL,
                                           k == STATE_BYTES - 1});
                coder_x = LOWER_BOUND;
            end
            default: ; // op 3: drop silently
        endcase
    endtask

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                              input logic [FREQ_W-1:0] freq, input logic [CUM_W-1:0] cum);
        send_beats.insert(send_beats.size(), t_beat'{op, sym, freq, cum});
    endtask

    // Driver: present the next beat once the slot is free, then hold off for
    // a random gap. The shadow coder advances on each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap = 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid)
                advance_coder(cur_beat);
            if (send_gap != 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (send_beats.size() != 0) begin
                cur_beat = send_beats.pop_front();
                in_if.valid     <= 1'b1;
                in_if.op        <= cur_beat.op;
                in_if.symbol    <= cur_beat.symbol;
                in_if.freq      <= cur_beat.freq;
                in_if.cum_start <= cur_beat.cum;
                if ($urandom_range(0, 49) == 0)
                    calm_in = !calm_in;
                send_gap = pick_gap(calm_in);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every result beat against the oldest prediction, then
    // stall the result side for a random, possibly empty, gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat byte %02h kind %0d last %0d",
                                            out_if.out_byte, out_if.kind, out_if.last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_if.out_byte !== want.data)
                        flag_mismatch($sformatf("out_byte %02h, want %02h",
                                                out_if.out_byte, want.data));
                    if (out_if.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d",
                                                out_if.kind, want.kind));
                    if (out_if.last !== want.last)
                        flag_mismatch($sformatf("last %0d, want %0d",
                                                out_if.last, want.last));
                end
                if ($urandom_range(0, 49) == 0)
                    calm_out = !calm_out;
                stall_left = pick_gap(calm_out);
            end else if (stall_left == 0 && !calm_out && $urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[%0t] timeout after %0d cycles", $realtime, cycle_cnt);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int unsigned rand_items;
        int unsigned n_sym;
        int unsigned n_enc;
        int unsigned rem;
        int unsigned share;
        int unsigned cap;
        int unsigned f;
        int unsigned cum;
        int unsigned pick;
        logic [SYM_W-1:0] sym_list [16];

        in_if.valid     = 1'b0;
        in_if.op        = '0;
        in_if.symbol    = '0;
        in_if.freq      = '0;
        in_if.cum_start = '0;
        out_if.ready    = 1'b0;
        mismatches      = 0;
        calm_in         = 1'b0;
        calm_out        = 1'b0;
        coder_x         = LOWER_BOUND;
        foreach (freq_of[i]) begin
            freq_of[i] = '0;
            cum_of[i]  = '0;
        end

        // Directed corner cases
        queue_beat(OP_ENCODE, 8'd0, '0, '0);              // never-loaded symbol
        queue_beat(OP_FLUSH, 8'd0, '0, '0);               // flush of the reset state
        queue_beat(OP_LOAD, 8'd0, 13'd4096, 12'd0);       // full-scale frequency
        queue_beat(OP_ENCODE, 8'd0, '1, '1);              // no renormalization
        queue_beat(OP_LOAD, 8'd255, 13'd1, 12'd4095);     // smallest frequency, top cum
        queue_beat(OP_ENCODE, 8'd255, '0, '0);            // one renorm byte
        queue_beat(OP_ENCODE, 8'd255, '0, '0);            // two renorm bytes
        queue_beat(OP_ENCODE, 8'd255, '0, '0);
        queue_beat(OP_LOAD, 8'h55, 13'h1FFF, 12'hAAA);    // frequency above the scale
        queue_beat(OP_ENCODE, 8'h55, '0, '0);
        queue_beat(OP_LOAD, 8'hAA, 13'd0, 12'hFFF);       // explicit zero frequency
        queue_beat(OP_ENCODE, 8'hAA, '0, '0);
        queue_beat(2'd3, 8'hFF, 13'h1FFF, 12'hFFF);       // unused op, all ones
        queue_beat(OP_LOAD, 8'd1, 13'd3, 12'd7);
        queue_beat(OP_ENCODE, 8'd1, '0, '0);
        queue_beat(OP_FLUSH, 8'hFF, '1, '1);
        queue_beat(OP_LOAD, 8'h80, 13'd2048, 12'd2048);
        queue_beat(OP_ENCODE, 8'h80, '0, '0);
        queue_beat(OP_ENCODE, 8'd1, '0, '0);
        queue_beat(OP_FLUSH, 8'd0, '0, '0);
        queue_beat(OP_LOAD, 8'hAA, 13'h1555, 12'h555);    // reload a zeroed entry
        queue_beat(OP_ENCODE, 8'hAA, '0, '0);
        queue_beat(OP_FLUSH, 8'd0, '0, '0);
        queue_beat(2'd3, 8'd0, '0, '0);                   // unused op, all zeros

        // Random part: mostly well-formed sequences (a normalized table, a run of
        // encodes from it, usually a flush), the rest single noise beats
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                n_sym = $urandom_range(2, 16);
                rem   = 1 << SCALE_BITS;
                share = 2 * rem / n_sym;
                cum   = 0;
                for (int i = 0; i < n_sym; i++) begin
                    sym_list[i] = SYM_W'($urandom);
                    if (i == n_sym - 1) begin
                        f = rem;
                    end else begin
                        cap = rem - (n_sym - 1 - i);
                        f   = $urandom_range(1, cap < share ? cap : share);
                    end
                    queue_beat(OP_LOAD, sym_list[i], FREQ_W'(f), CUM_W'(cum));
                    cum += f;
                    rem -= f;
                end
                n_enc = $urandom_range(4, 20);
                for (int i = 0; i < n_enc; i++) begin
                    pick = $urandom_range(0, n_sym - 1);
                    queue_beat(OP_ENCODE, sym_list[pick], FREQ_W'($urandom), CUM_W'($urandom));
                end
                rand_items += n_sym + n_enc;
                if ($urandom_range(0, 3) != 0) begin
                    queue_beat(OP_FLUSH, SYM_W'($urandom), FREQ_W'($urandom), CUM_W'($urandom));
                    rand_items++;
                end
            end else begin
                // Noise: any op with any field values, including invalid tables
                queue_beat(OP_W'($urandom), SYM_W'($urandom), FREQ_W'($urandom),
                           CUM_W'($urandom));
                rand_items++;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge so nothing races the driver or the monitor
        while (send_beats.size() != 0 || in_if.valid || expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_bytes.size() != 0)
            flag_mismatch($sformatf("%0d result beats never arrived", expected_bytes.size()));

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
